/* sv/pdb_pkg.sv */
// ----------------------------------------------------------------------------
// pdb_pkg
// Types, codes and the sequencer program of the page split descriptor builder.
// ----------------------------------------------------------------------------
package pdb_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_LEN  = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

  // register indexes on the configuration port
  localparam logic REG_TABLE_BASE = 1'b0;
  localparam logic REG_MAX_CHUNK  = 1'b1;

  // smallest chunk limit the datapath uses
  localparam logic [12:0] MIN_CHUNK = 13'd4;

  // jump conditions of the sequencer
  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_IDLE   = 3'd2;  // no start request
  localparam logic [2:0] COND_ZERO   = 3'd3;  // request byte count is zero
  localparam logic [2:0] COND_MORE   = 3'd4;  // another chunk fits in the table
  localparam logic [2:0] COND_LEFT   = 3'd5;  // bytes remain after the scan

  // program steps
  localparam logic [3:0] STEP_IDLE  = 4'd0;
  localparam logic [3:0] STEP_LOAD  = 4'd1;
  localparam logic [3:0] STEP_SCAN  = 4'd2;
  localparam logic [3:0] STEP_CHECK = 4'd3;
  localparam logic [3:0] STEP_RELD  = 4'd4;
  localparam logic [3:0] STEP_EMIT  = 4'd5;
  localparam logic [3:0] STEP_RET   = 4'd6;
  localparam logic [3:0] STEP_ZERO  = 4'd7;
  localparam logic [3:0] STEP_EXH   = 4'd8;

  // one control word
  typedef struct packed {
    logic       load;    // reload the work registers from the request
    logic       step;    // advance address, remaining count and index
    logic       emit;    // drive a result
    logic [1:0] err;     // status of the emitted result
    logic [2:0] cond;    // jump condition
    logic [3:0] target;  // jump target, else the next step
  } ucode_t;

  // read-only program
  function automatic ucode_t ucode_rom(input logic [3:0] pc);
    ucode_t cw;
    cw = '{load: 1'b0, step: 1'b0, emit: 1'b0, err: STATUS_OK,
           cond: COND_ALWAYS, target: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        cw.cond   = COND_IDLE;
        cw.target = STEP_IDLE;
      end
      STEP_LOAD: begin
        cw.load   = 1'b1;
        cw.cond   = COND_ZERO;
        cw.target = STEP_ZERO;
      end
      STEP_SCAN: begin
        cw.step   = 1'b1;
        cw.cond   = COND_MORE;
        cw.target = STEP_SCAN;
      end
      STEP_CHECK: begin
        cw.cond   = COND_LEFT;
        cw.target = STEP_EXH;
      end
      STEP_RELD: begin
        cw.load = 1'b1;
        cw.cond = COND_NEVER;
      end
      STEP_EMIT: begin
        cw.step   = 1'b1;
        cw.emit   = 1'b1;
        cw.cond   = COND_MORE;
        cw.target = STEP_EMIT;
      end
      STEP_RET: begin
        cw.cond = COND_ALWAYS;
      end
      STEP_ZERO: begin
        cw.emit = 1'b1;
        cw.err  = STATUS_ZERO_LEN;
      end
      STEP_EXH: begin
        cw.emit = 1'b1;
        cw.err  = STATUS_EXHAUSTED;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

/* sv/page_split_dma_descriptor_builder.sv */
// ----------------------------------------------------------------------------
// page_split_dma_descriptor_builder
// Cuts one buffer request into a chain of page-bounded DMA descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   A request (start_addr, byte_count) is taken at a clock edge with start
//   high and busy low. busy stays high until the final result of the request
//   is on the result ports. Results come out one per cycle, each marked by
//   done for one cycle; the receiver cannot hold them off. last marks the
//   final result of a request.
//   A small microcoded sequencer runs two passes over the chunk loop: a scan
//   pass that counts the chunks, then an emit pass that drives one
//   descriptor per cycle. A chain that does not fit in the table gives one
//   result with the exhausted status, a zero byte count one zero-length result.
//   The first descriptor of a request is on the ports after the scan pass,
//   the rest back to back. An exhausted result also follows the scan pass;
//   a zero-length result needs no scan pass. Registers table_base and
//   max_chunk are to be written over the APB port only while the block is
//   idle; the block itself does not enforce this. Reset returns the
//   sequencer to idle and the registers to table_base 0 and max_chunk 4096.
//   PAGE_BYTES must be a power of two; the block does not check this.
// ----------------------------------------------------------------------------
module page_split_dma_descriptor_builder #(
  parameter int PAGE_BYTES      = 4096,
  parameter int MAX_DESCRIPTORS = 64,
  parameter int DESC_BYTES      = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [31:0] start_addr,
  input  logic [18:0] byte_count,
  // result channel
  output logic        done,
  output logic [28:0] chunk_addr,
  output logic [12:0] chunk_bytes,
  output logic        end_mark,
  output logic [28:0] next_desc_addr,
  output logic [5:0]  desc_index,
  output logic [1:0]  status,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pdb_pkg::*;

  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int IDX_W  = $clog2(MAX_DESCRIPTORS + 1);
  localparam int OFF_W  = IDX_W + 6;
  localparam int CW     = 20;

  // configuration registers
  logic [28:0] table_base;
  logic [12:0] max_chunk;

  // sequencer and datapath registers
  logic [3:0]       pc;
  logic [3:0]       pc_next;
  logic [31:0]      req_addr;
  logic [18:0]      req_count;
  logic [31:0]      addr;
  logic [18:0]      rem;
  logic [IDX_W-1:0] idx;

  ucode_t cw;
  logic   take;

  // chunk computation
  logic [12:0]      limit;
  logic [PAGE_W:0]  page_left;
  logic [CW-1:0]    bytes;
  logic [CW-1:0]    bytes_pg;
  logic [18:0]      rem_after;
  logic [IDX_W-1:0] idx_inc;
  logic [OFF_W-1:0] desc_off;
  logic             more;
  logic             chunk_end;

  // apb write and read
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= 29'd0;
      max_chunk  <= 13'd4096;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TABLE_BASE: table_base <= pwdata[28:0];
        REG_MAX_CHUNK:  max_chunk  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TABLE_BASE: prdata = {3'd0, table_base};
      REG_MAX_CHUNK:  prdata = {19'd0, max_chunk};
      default:        prdata = 32'd0;
    endcase
  end

  // chunk size: min of remaining, limit and bytes left in the page
  always_comb begin
    limit     = (max_chunk < MIN_CHUNK) ? MIN_CHUNK : max_chunk;
    page_left = (PAGE_W + 1)'(PAGE_BYTES) - {1'b0, addr[PAGE_W-1:0]};
    bytes     = (CW'(rem) > CW'(limit)) ? CW'(limit) : CW'(rem);
    bytes_pg  = (bytes > CW'(page_left)) ? CW'(page_left) : bytes;
    rem_after = rem - bytes_pg[18:0];
    idx_inc   = idx + IDX_W'(1);
    desc_off  = OFF_W'(idx_inc) * OFF_W'(DESC_BYTES);
    chunk_end = (rem_after == 19'd0);
    more      = !chunk_end && (idx_inc < IDX_W'(MAX_DESCRIPTORS));
  end

  // sequencer: fetch, evaluate jump condition
  assign cw   = ucode_rom(pc);
  assign busy = (pc != STEP_IDLE);

  always_comb begin
    case (cw.cond)
      COND_NEVER:  take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_IDLE:   take = !start;
      COND_ZERO:   take = (req_count == 19'd0);
      COND_MORE:   take = more;
      COND_LEFT:   take = (rem != 19'd0);
      default:     take = 1'b1;
    endcase
    pc_next = take ? cw.target : pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (pc == STEP_IDLE && start) begin
      req_addr  <= start_addr;
      req_count <= byte_count;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (cw.load) begin
      addr <= req_addr;
      rem  <= req_count;
      idx  <= '0;
    end else if (cw.step) begin
      addr <= addr + {12'd0, bytes_pg[19:2], 2'b00};
      rem  <= rem_after;
      idx  <= idx_inc;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cw.emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cw.emit) begin
      if (cw.err == STATUS_OK) begin
        chunk_addr     <= addr[28:0];
        chunk_bytes    <= bytes_pg[12:0];
        end_mark       <= chunk_end;
        next_desc_addr <= chunk_end ? 29'd0 : table_base + 29'(desc_off);
        desc_index     <= 6'(idx);
        status         <= STATUS_OK;
        last           <= chunk_end;
      end else begin
        chunk_addr     <= 29'd0;
        chunk_bytes    <= 13'd0;
        end_mark       <= 1'b0;
        next_desc_addr <= 29'd0;
        desc_index     <= 6'd0;
        status         <= cw.err;
        last           <= 1'b1;
      end
    end
  end

  // checks
  a_done_from_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cw.emit))
    else $error("result strobe without an emit step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but sequencer stayed idle");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (last && !end_mark))
    else $error("error result not final");

  a_end_link: assert property (@(posedge clk) disable iff (rst)
    (done && end_mark) |-> (last && next_desc_addr == 29'd0))
    else $error("chain end with a link or without last");

endmodule
